### hdl/mch_pkg.sv
package mch_pkg;

  localparam int SCALE_FRAC_BITS   = 14;
  localparam int HEADING_FRAC_BITS = 6;

  localparam int RAW_W   = 16;
  localparam int FIELD_W = 16;
  localparam int REG_W   = 48;
  localparam int CAL_W   = 18;
  localparam int HEAD_W  = 15;
  localparam int DIFF_W  = RAW_W + 1;
  localparam int PROD_W  = FIELD_W + DIFF_W;
  localparam int ACC_W   = PROD_W + 2;

  localparam int IN_DATA_W  = 3 * RAW_W;
  localparam int OUT_BITS   = 3 * CAL_W + HEAD_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
  localparam int OUT_PAD_W  = OUT_DATA_W - OUT_BITS;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_X = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_Y = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_Z = 2'd3;

  localparam logic [FIELD_W-1:0] SCALE_ONE = FIELD_W'(1 << SCALE_FRAC_BITS);
  localparam logic signed [ACC_W-1:0] SCALE_RND = ACC_W'(1 << (SCALE_FRAC_BITS - 1));
  localparam logic signed [ACC_W-1:0] CAL_MAX = ACC_W'((1 << (CAL_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] CAL_MIN = ACC_W'(-(1 << (CAL_W - 1)));

  localparam int ANG_FRAC        = 20;
  localparam int CORDIC_STEPS    = 24;
  localparam int STEPS_PER_STAGE = 2;
  localparam int CORDIC_STAGES   = CORDIC_STEPS / STEPS_PER_STAGE;
  localparam int PRE_SHIFT       = 16;
  localparam int XW              = 38;
  localparam int ZW              = 32;

  localparam logic signed [ZW-1:0] ANG_180  = ZW'(180 << ANG_FRAC);
  localparam logic signed [ZW-1:0] ANG_360  = ZW'(360 << ANG_FRAC);
  localparam logic signed [ZW-1:0] HEAD_RND = ZW'(1 << (ANG_FRAC - HEADING_FRAC_BITS - 1));
  localparam int HEAD_SHIFT = ANG_FRAC - HEADING_FRAC_BITS;
  localparam logic [ZW-1:0] HEAD_FULL = ZW'(360 << HEADING_FRAC_BITS);

  typedef struct packed {
    logic signed [CAL_W-1:0] z;
    logic signed [CAL_W-1:0] y;
    logic signed [CAL_W-1:0] x;
  } cal_t;

  typedef struct packed {
    logic                 zero;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] ang;
    cal_t                 cal;
  } cordic_t;

  function automatic logic signed [FIELD_W-1:0] field16(input logic [REG_W-1:0] r,
                                                        input int k);
    return $signed(r[FIELD_W*k +: FIELD_W]);
  endfunction

  function automatic logic signed [ZW-1:0] atan_deg(input int i);
    logic signed [ZW-1:0] t;
    case (i)
      0:  t = ZW'(47185920);
      1:  t = ZW'(27855475);
      2:  t = ZW'(14718068);
      3:  t = ZW'(7471121);
      4:  t = ZW'(3750058);
      5:  t = ZW'(1876857);
      6:  t = ZW'(938658);
      7:  t = ZW'(469357);
      8:  t = ZW'(234682);
      9:  t = ZW'(117342);
      10: t = ZW'(58671);
      11: t = ZW'(29335);
      12: t = ZW'(14668);
      13: t = ZW'(7334);
      14: t = ZW'(3667);
      15: t = ZW'(1833);
      16: t = ZW'(917);
      17: t = ZW'(458);
      18: t = ZW'(229);
      19: t = ZW'(115);
      20: t = ZW'(57);
      21: t = ZW'(29);
      22: t = ZW'(14);
      23: t = ZW'(7);
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

### hdl/mch_calib.sv
module mch_calib (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               ce_i,
  input  logic                               in_vld_i,
  input  logic [mch_pkg::IN_DATA_W-1:0]      raw_i,
  input  logic                               cfg_we_i,
  input  logic [mch_pkg::CFG_IDX_W-1:0]      cfg_addr_i,
  input  logic [mch_pkg::REG_W-1:0]          cfg_wdata_i,
  output logic                               out_vld_o,
  output mch_pkg::cal_t                      out_cal_o
);

  logic [mch_pkg::REG_W-1:0] bias_q;
  logic [mch_pkg::REG_W-1:0] row_q [3];

  logic [2:0] vld_q;

  logic signed [mch_pkg::DIFF_W-1:0] d_d [3];
  logic signed [mch_pkg::DIFF_W-1:0] d_q [3];
  logic signed [mch_pkg::PROD_W-1:0] p_d [3][3];
  logic signed [mch_pkg::PROD_W-1:0] p_q [3][3];
  logic signed [mch_pkg::CAL_W-1:0]  c_d [3];
  mch_pkg::cal_t                     cal_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_q   <= '0;
      row_q[0] <= mch_pkg::REG_W'(mch_pkg::SCALE_ONE);
      row_q[1] <= mch_pkg::REG_W'(mch_pkg::SCALE_ONE) << mch_pkg::FIELD_W;
      row_q[2] <= mch_pkg::REG_W'(mch_pkg::SCALE_ONE) << (2 * mch_pkg::FIELD_W);
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        mch_pkg::CFG_BIAS:  bias_q   <= cfg_wdata_i;
        mch_pkg::CFG_ROW_X: row_q[0] <= cfg_wdata_i;
        mch_pkg::CFG_ROW_Y: row_q[1] <= cfg_wdata_i;
        mch_pkg::CFG_ROW_Z: row_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      d_d[k] = mch_pkg::DIFF_W'($signed(raw_i[mch_pkg::RAW_W*k +: mch_pkg::RAW_W]))
             - mch_pkg::DIFF_W'(mch_pkg::field16(bias_q, k));
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        p_d[r][k] = mch_pkg::PROD_W'(mch_pkg::field16(row_q[r], k))
                  * mch_pkg::PROD_W'(d_q[k]);
      end
    end
  end

  always_comb begin
    logic signed [mch_pkg::ACC_W-1:0] acc;
    logic signed [mch_pkg::ACC_W-1:0] sh;
    for (int r = 0; r < 3; r++) begin
      acc = mch_pkg::ACC_W'(p_q[r][0]) + mch_pkg::ACC_W'(p_q[r][1])
          + mch_pkg::ACC_W'(p_q[r][2]) + mch_pkg::SCALE_RND;
      sh = acc >>> mch_pkg::SCALE_FRAC_BITS;
      if (sh > mch_pkg::CAL_MAX) begin
        c_d[r] = mch_pkg::CAL_W'(mch_pkg::CAL_MAX);
      end else if (sh < mch_pkg::CAL_MIN) begin
        c_d[r] = mch_pkg::CAL_W'(mch_pkg::CAL_MIN);
      end else begin
        c_d[r] = sh[mch_pkg::CAL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ce_i) begin
      vld_q <= {vld_q[1:0], in_vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      d_q   <= d_d;
      p_q   <= p_d;
      cal_q <= '{z: c_d[2], y: c_d[1], x: c_d[0]};
    end
  end

  assign out_vld_o = vld_q[2];
  assign out_cal_o = cal_q;

endmodule

### hdl/mch_cordic.sv
module mch_cordic (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             ce_i,
  input  logic             in_vld_i,
  input  mch_pkg::cal_t    in_cal_i,
  output logic             out_vld_o,
  output mch_pkg::cordic_t out_o
);

  mch_pkg::cordic_t pre_d;
  mch_pkg::cordic_t st_q [mch_pkg::CORDIC_STAGES+1];
  mch_pkg::cordic_t st_d [mch_pkg::CORDIC_STAGES];
  logic [mch_pkg::CORDIC_STAGES:0] vld_q;

  always_comb begin
    logic signed [mch_pkg::XW-1:0] xi;
    logic signed [mch_pkg::XW-1:0] yi;
    xi = mch_pkg::XW'(in_cal_i.x) <<< mch_pkg::PRE_SHIFT;
    yi = mch_pkg::XW'(in_cal_i.y) <<< mch_pkg::PRE_SHIFT;
    pre_d.zero = (in_cal_i.x == '0) && (in_cal_i.y == '0);
    pre_d.cal  = in_cal_i;
    if (xi < 0) begin
      pre_d.x   = -xi;
      pre_d.y   = -yi;
      pre_d.ang = mch_pkg::ANG_180;
    end else begin
      pre_d.x   = xi;
      pre_d.y   = yi;
      pre_d.ang = '0;
    end
  end

  always_comb begin
    mch_pkg::cordic_t c;
    logic signed [mch_pkg::XW-1:0] nx;
    logic signed [mch_pkg::XW-1:0] ny;
    int idx;
    for (int g = 0; g < mch_pkg::CORDIC_STAGES; g++) begin
      c = st_q[g];
      for (int j = 0; j < mch_pkg::STEPS_PER_STAGE; j++) begin
        idx = g * mch_pkg::STEPS_PER_STAGE + j;
        if (!c.y[mch_pkg::XW-1]) begin
          nx    = c.x + (c.y >>> idx);
          ny    = c.y - (c.x >>> idx);
          c.ang = c.ang + mch_pkg::atan_deg(idx);
        end else begin
          nx    = c.x - (c.y >>> idx);
          ny    = c.y + (c.x >>> idx);
          c.ang = c.ang - mch_pkg::atan_deg(idx);
        end
        c.x = nx;
        c.y = ny;
      end
      st_d[g] = c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ce_i) begin
      vld_q <= {vld_q[mch_pkg::CORDIC_STAGES-1:0], in_vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      st_q[0] <= pre_d;
      for (int g = 0; g < mch_pkg::CORDIC_STAGES; g++) begin
        st_q[g+1] <= st_d[g];
      end
    end
  end

  assign out_vld_o = vld_q[mch_pkg::CORDIC_STAGES];
  assign out_o     = st_q[mch_pkg::CORDIC_STAGES];

endmodule

### hdl/mch_heading_out.sv
module mch_heading_out (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            ce_i,
  input  logic                            in_vld_i,
  input  mch_pkg::cordic_t                in_i,
  output logic                            out_vld_o,
  output logic [mch_pkg::OUT_DATA_W-1:0]  out_data_o
);

  logic                          a_vld_q;
  logic                          a_zero_q;
  logic signed [mch_pkg::ZW-1:0] a_ang_d;
  logic signed [mch_pkg::ZW-1:0] a_ang_q;
  mch_pkg::cal_t                 a_cal_q;

  logic                              o_vld_q;
  logic [mch_pkg::OUT_DATA_W-1:0]    o_data_d;
  logic [mch_pkg::OUT_DATA_W-1:0]    o_data_q;

  assign a_ang_d = in_i.ang + (in_i.ang[mch_pkg::ZW-1] ?
                               mch_pkg::ANG_360 + mch_pkg::HEAD_RND : mch_pkg::HEAD_RND);

  always_comb begin
    logic [mch_pkg::ZW-1:0] h;
    logic [mch_pkg::HEAD_W-1:0] head;
    h = $unsigned(a_ang_q) >> mch_pkg::HEAD_SHIFT;
    if (h >= mch_pkg::HEAD_FULL) begin
      h = h - mch_pkg::HEAD_FULL;
    end
    head = a_zero_q ? '0 : h[mch_pkg::HEAD_W-1:0];
    o_data_d = {{mch_pkg::OUT_PAD_W{1'b0}}, head, a_cal_q.z, a_cal_q.y, a_cal_q.x};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      o_vld_q <= 1'b0;
    end else if (ce_i) begin
      a_vld_q <= in_vld_i;
      o_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      a_zero_q <= in_i.zero;
      a_ang_q  <= a_ang_d;
      a_cal_q  <= in_i.cal;
      o_data_q <= o_data_d;
    end
  end

  assign out_vld_o  = o_vld_q;
  assign out_data_o = o_data_q;

endmodule

### hdl/magnetometer_calibrate_heading_unit.sv
// Calibrates one raw three-axis magnetometer sample per clock: subtracts the hard-iron bias,
// applies the Q2.14 soft-iron matrix with round-half-up and saturation to 18 bits, and
// derives the heading atan2(cal_y, cal_x) in 1/64 degree, 0 up to below 360, by a 24-step
// CORDIC. One request enters every cycle while the output is not stalled; each result passes
// through three calibration stages (bias, multiply, sum), one pre-rotation stage, twelve
// CORDIC stages of two steps each and two heading stages. The whole pipe holds while
// a result waits at the output. Write configuration only while no request is in flight.
module magnetometer_calibrate_heading_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // raw_x [15:0], raw_y [31:16], raw_z [47:32]
  input  logic [mch_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // cal_x [17:0], cal_y [35:18], cal_z [53:36], heading [68:54], zero fill above
  output logic [mch_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  input  logic                              cfg_we_i,
  input  logic [mch_pkg::CFG_IDX_W-1:0]     cfg_addr_i,
  input  logic [mch_pkg::REG_W-1:0]         cfg_wdata_i
);

  logic             ce;
  logic             cal_vld;
  mch_pkg::cal_t    cal;
  logic             cor_vld;
  mch_pkg::cordic_t cor;

  assign ce            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = ce;

  mch_calib u_calib (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ce_i        (ce),
    .in_vld_i    (s_axis_tvalid),
    .raw_i       (s_axis_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_vld_o   (cal_vld),
    .out_cal_o   (cal)
  );

  mch_cordic u_cordic (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ce_i      (ce),
    .in_vld_i  (cal_vld),
    .in_cal_i  (cal),
    .out_vld_o (cor_vld),
    .out_o     (cor)
  );

  mch_heading_out u_heading_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ce_i       (ce),
    .in_vld_i   (cor_vld),
    .in_i       (cor),
    .out_vld_o  (m_axis_tvalid),
    .out_data_o (m_axis_tdata)
  );

endmodule

### hdl/mch_checker.sv
module mch_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [mch_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

  logic [mch_pkg::HEAD_W-1:0] head;
  logic [mch_pkg::CAL_W-1:0]  cal_x;
  logic [mch_pkg::CAL_W-1:0]  cal_y;

  assign head  = m_axis_tdata[3*mch_pkg::CAL_W +: mch_pkg::HEAD_W];
  assign cal_x = m_axis_tdata[0 +: mch_pkg::CAL_W];
  assign cal_y = m_axis_tdata[mch_pkg::CAL_W +: mch_pkg::CAL_W];

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output slot");

  a_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ({17'd0, head} < mch_pkg::HEAD_FULL))
    else $error("heading out of range");

  a_zero_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (cal_x == '0) && (cal_y == '0) |-> (head == '0))
    else $error("zero vector with nonzero heading");

endmodule

bind magnetometer_calibrate_heading_unit mch_checker u_mch_checker (.*);
